[design/strided_scatter_add_accumulator_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the scatter-add accumulator checkers
// Immediate-cycle and next-cycle implication forms, gated by reset.
// ----------------------------------------------------------------------------
`ifndef STRIDED_SCATTER_ADD_ACCUMULATOR_TOP_ASSERT_SVH
`define STRIDED_SCATTER_ADD_ACCUMULATOR_TOP_ASSERT_SVH

// same-cycle implication
`define SSAA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssaa port check failed");

// next-cycle implication
`define SSAA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssaa port check failed");

`endif

[design/ssaa_pkg.sv]
// ----------------------------------------------------------------------------
// ssaa_pkg
// Shared widths and register codes of the strided scatter-add accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssaa_pkg;

  localparam int NumIdx   = 4;
  localparam int IdxW     = 16;
  localparam int ValW     = 32;
  localparam int ProdW    = 2 * IdxW;
  localparam int AddrSumW = ProdW + 2;
  localparam int ElemW    = 16;
  localparam int DimsW    = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgDims    = 3'd0;
  localparam cfg_idx_t CfgStride0 = 3'd1;
  localparam cfg_idx_t CfgStride1 = 3'd2;
  localparam cfg_idx_t CfgStride2 = 3'd3;
  localparam cfg_idx_t CfgStride3 = 3'd4;
  localparam cfg_idx_t CfgComplex = 3'd5;

  localparam logic [DimsW-1:0] DimsReset    = 3'd1;
  localparam logic [IdxW-1:0]  Stride0Reset = 16'd1;

endpackage

[design/ssaa_if.sv]
// ----------------------------------------------------------------------------
// ssaa_if
// Valid/ready channels for index/value items and accumulated results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ssaa_in_if;
  logic                            valid;
  logic                            ready;
  logic        [ssaa_pkg::IdxW-1:0] index_0;
  logic        [ssaa_pkg::IdxW-1:0] index_1;
  logic        [ssaa_pkg::IdxW-1:0] index_2;
  logic        [ssaa_pkg::IdxW-1:0] index_3;
  logic signed [ssaa_pkg::ValW-1:0] data_re;
  logic signed [ssaa_pkg::ValW-1:0] data_im;

  modport source (output valid, index_0, index_1, index_2, index_3, data_re, data_im,
                  input ready);
  modport sink   (input valid, index_0, index_1, index_2, index_3, data_re, data_im,
                  output ready);
endinterface

interface ssaa_out_if;
  logic                             valid;
  logic                             ready;
  logic        [ssaa_pkg::ElemW-1:0] elem_address;
  logic signed [ssaa_pkg::ValW-1:0]  sum_re;
  logic signed [ssaa_pkg::ValW-1:0]  sum_im;
  logic                             out_of_range;

  modport source (output valid, elem_address, sum_re, sum_im, out_of_range,
                  input ready);
  modport sink   (input valid, elem_address, sum_re, sum_im, out_of_range,
                  output ready);
endinterface

[design/strided_scatter_add_accumulator_top.sv]
// ----------------------------------------------------------------------------
// strided_scatter_add_accumulator_top
// Strided scatter-add: a[sum(index_d * stride_d)] += value, real or complex.
//
//   Channel   Dir  Handshake      Content
//   in_ch     in   valid/ready    index_0..3, data_re, data_im
//   out_ch    out  valid/ready    elem_address, sum_re, sum_im, out_of_range
//   cfg_*     in   write enable   register index, write data
//
// Steps per item: multiply on accept, address sum and memory read, add and
// write-back; the single memory takes a new item only after write-back.
// After reset a clearing pass zeroes every memory word before the first item.
// A result waiting on out_ch holds the block in write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module strided_scatter_add_accumulator_top #(
  parameter int ADDR_BITS = 16,
  parameter int MAX_DIMS  = 4,
  parameter int DATA_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ssaa_in_if.sink                        in_ch,
  ssaa_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ssaa_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ssaa_pkg::CfgDataW-1:0]  cfg_wdata
);

  localparam int UsedDims = (MAX_DIMS < ssaa_pkg::NumIdx) ? MAX_DIMS : ssaa_pkg::NumIdx;
  localparam int WordW    = 2 * DATA_BITS;
  localparam int Depth    = 2 ** ADDR_BITS;

  typedef enum logic [3:0] {
    ST_CLR  = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_RD   = 4'b0100,
    ST_WR   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [ssaa_pkg::DimsW-1:0] dims_r;
  logic [ssaa_pkg::IdxW-1:0]  stride_r [ssaa_pkg::NumIdx];
  logic                       cplx_r;

  logic [ADDR_BITS-1:0]       clr_cnt_r;
  logic [ssaa_pkg::ProdW-1:0] prod_r [ssaa_pkg::NumIdx];
  logic signed [ssaa_pkg::ValW-1:0] data_re_r, data_im_r;

  logic [ssaa_pkg::AddrSumW-1:0] addr_sum;
  logic [ADDR_BITS-1:0]          waddr_r;
  logic [ssaa_pkg::ElemW-1:0]    elem_r;
  logic                          oor_r;

  logic [WordW-1:0]     mem [Depth];
  logic [WordW-1:0]     rd_r;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [WordW-1:0]     mem_wdata;

  logic [DATA_BITS-1:0] new_re, new_im;
  logic [ssaa_pkg::IdxW-1:0] in_idx [ssaa_pkg::NumIdx];

  logic                          out_valid_r;
  logic [ssaa_pkg::ElemW-1:0]    out_elem_r;
  logic [ssaa_pkg::ValW-1:0]     out_re_r, out_im_r;
  logic                          out_oor_r;

  logic accept, out_free, wr_go;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign wr_go    = (state_r == ST_WR) && out_free;

  assign in_ch.ready = (state_r == ST_IDLE);

  assign in_idx[0] = in_ch.index_0;
  assign in_idx[1] = in_ch.index_1;
  assign in_idx[2] = in_ch.index_2;
  assign in_idx[3] = in_ch.index_3;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r      <= ssaa_pkg::DimsReset;
      stride_r[0] <= ssaa_pkg::Stride0Reset;
      stride_r[1] <= '0;
      stride_r[2] <= '0;
      stride_r[3] <= '0;
      cplx_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssaa_pkg::CfgDims:    dims_r      <= cfg_wdata[ssaa_pkg::DimsW-1:0];
        ssaa_pkg::CfgStride0: stride_r[0] <= cfg_wdata;
        ssaa_pkg::CfgStride1: stride_r[1] <= cfg_wdata;
        ssaa_pkg::CfgStride2: stride_r[2] <= cfg_wdata;
        ssaa_pkg::CfgStride3: stride_r[3] <= cfg_wdata;
        ssaa_pkg::CfgComplex: cplx_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (&clr_cnt_r) state_nxt = ST_IDLE;
      ST_IDLE: if (accept) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_WR;
      ST_WR:   if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_BITS'(1);
      end
    end
  end

  // stage 1: per-dimension products on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int d = 0; d < ssaa_pkg::NumIdx; d++) begin
        if ((d < UsedDims) && (32'(dims_r) > d)) begin
          prod_r[d] <= ssaa_pkg::ProdW'(in_idx[d]) * ssaa_pkg::ProdW'(stride_r[d]);
        end else begin
          prod_r[d] <= '0;
        end
      end
      data_re_r <= in_ch.data_re;
      data_im_r <= in_ch.data_im;
    end
  end

  // stage 2: address sum, range check, memory read
  always_comb begin
    addr_sum = '0;
    for (int d = 0; d < ssaa_pkg::NumIdx; d++) begin
      addr_sum = addr_sum + ssaa_pkg::AddrSumW'(prod_r[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      waddr_r <= addr_sum[ADDR_BITS-1:0];
      elem_r  <= addr_sum[ssaa_pkg::ElemW-1:0];
      oor_r   <= (addr_sum[ssaa_pkg::AddrSumW-1:ADDR_BITS] != '0);
      rd_r    <= mem[addr_sum[ADDR_BITS-1:0]];
    end
  end

  // stage 3: accumulate and write back
  assign new_re = rd_r[DATA_BITS-1:0]     + DATA_BITS'(data_re_r);
  assign new_im = rd_r[WordW-1:DATA_BITS] + DATA_BITS'(data_im_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = waddr_r;
    mem_wdata = {(cplx_r ? new_im : rd_r[WordW-1:DATA_BITS]), new_re};
    if (state_r == ST_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (wr_go && !oor_r) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wr_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      out_elem_r <= elem_r;
      out_oor_r  <= oor_r;
      out_re_r   <= oor_r ? '0 : ssaa_pkg::ValW'(new_re);
      out_im_r   <= (oor_r || !cplx_r) ? '0 : ssaa_pkg::ValW'(new_im);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.elem_address = out_elem_r;
  assign out_ch.sum_re       = out_re_r;
  assign out_ch.sum_im       = out_im_r;
  assign out_ch.out_of_range = out_oor_r;

endmodule

[design/ssaa_checker.sv]
// ----------------------------------------------------------------------------
// ssaa_checker
// Port-level checks of the scatter-add accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "strided_scatter_add_accumulator_top_assert.svh"

module ssaa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_of_range,
  input logic [ssaa_pkg::ValW-1:0]      sum_re,
  input logic [ssaa_pkg::ValW-1:0]      sum_im
);

  `SSAA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `SSAA_ASSERT_IMP(a_oor_zero, clk, rst_n, out_valid && out_of_range, (sum_re == '0) && (sum_im == '0))
  `SSAA_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
  `SSAA_ASSERT_IMP(a_clear_after_reset, clk, rst_n, $rose(rst_n), !in_ready)

endmodule

bind strided_scatter_add_accumulator_top ssaa_checker u_ssaa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_of_range (out_ch.out_of_range),
  .sum_re       (out_ch.sum_re),
  .sum_im       (out_ch.sum_im)
);
